// ----- src/dedup_request_queue_with_answers_defines.svh -----
// Assertion macros shared by the request queue RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef DEDUP_REQUEST_QUEUE_WITH_ANSWERS_DEFINES_SVH
`define DEDUP_REQUEST_QUEUE_WITH_ANSWERS_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define DRQ_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define DRQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/drq_pkg.sv -----
// Types, constants and control structs of the pairing request queue.
// No dependencies; every other file but drq_ram and the macro header imports it.
package drq_pkg;

   localparam int TYPE_W            = 3;
   localparam int ADDR_W            = 48;
   localparam int INFO_W            = 32;
   localparam int MAXC_W            = 5;
   localparam int MAX_RESULTS       = 16;
   localparam int DEF_QUEUE_DEPTH   = 16;
   localparam int DEF_ANSWER_DEPTH  = 16;

   typedef enum logic [TYPE_W-1:0] {
      OP_PUSH     = 3'd0,
      OP_TAKE     = 3'd1,
      OP_ANSWER   = 3'd2,
      OP_TAKE_ANS = 3'd3,
      OP_CLEAR    = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      OUT_NONE,
      OUT_REQ,
      OUT_ANS
   } out_kind_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_DECODE,
      ST_P_SCAN_RD,
      ST_P_SCAN_CMP,
      ST_P_SHIFT_RD,
      ST_P_SHIFT_WR,
      ST_P_APPEND,
      ST_A_SCAN_RD,
      ST_A_SCAN_CMP,
      ST_A_SHIFT_RD,
      ST_A_SHIFT_WR,
      ST_A_APPEND,
      ST_TAKE_RD,
      ST_TAKE_EMIT,
      ST_EMIT_NONE,
      ST_EMIT_ANS
   } state_type;

   typedef struct packed {
      logic off_clr;
      logic off_inc;
      logic rd_cur;
      logic rd_next;
      logic wr_shift;
      logic append;
      logic dec;
      logic pop;
      logic clear;
   } store_cmd_type;

   typedef struct packed {
      logic at_end;
      logic shift_end;
      logic empty;
      logic one_left;
      logic hit;
   } store_status_type;

   typedef struct packed {
      logic          load_req;
      store_cmd_type pend;
      store_cmd_type ans;
      logic          latch_allow;
      logic          rem_dec;
      logic          out_load;
      out_kind_type  out_kind;
      logic          out_last;
   } dp_cmd_type;

   typedef struct packed {
      op_type           op;
      logic             addr_zero;
      logic             rem_zero;
      logic             rem_one;
      logic             out_free;
      store_status_type pend;
      store_status_type ans;
   } dp_status_type;

endpackage

// ----- src/drq_req_if.sv -----
// Request channel: valid/ready handshake plus the request fields.
// Depends on drq_pkg.
interface drq_req_if import drq_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [TYPE_W-1:0] req_type;
   logic [ADDR_W-1:0] addr;
   logic [INFO_W-1:0] ask_info;
   logic [MAXC_W-1:0] max_count;
   logic              allow_in;

   modport source (output valid, req_type, addr, ask_info, max_count, allow_in,
                   input ready);
   modport sink   (input valid, req_type, addr, ask_info, max_count, allow_in,
                   output ready);
endinterface

// ----- src/drq_rsp_if.sv -----
// Result channel: valid/ready handshake plus the result fields.
// Depends on drq_pkg.
interface drq_rsp_if import drq_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              item_valid;
   logic [ADDR_W-1:0] item_addr;
   logic [INFO_W-1:0] item_info;
   logic              found;
   logic              allow_out;
   logic              last;

   modport source (output valid, item_valid, item_addr, item_info, found, allow_out, last,
                   input ready);
   modport sink   (input valid, item_valid, item_addr, item_info, found, allow_out, last,
                   output ready);
endinterface

// ----- src/drq_ram.sv -----
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module drq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/drq_store.sv -----
// One bounded ordered store (circular RAM with head, count and walk offset).
// Depends on drq_pkg, drq_ram and the assertion macro header.
`include "dedup_request_queue_with_answers_defines.svh"

module drq_store import drq_pkg::*; #(
   parameter int DEPTH     = DEF_QUEUE_DEPTH,
   parameter int PAYLOAD_W = INFO_W
) (
   input  logic                  clock,
   input  logic                  reset,
   input  store_cmd_type         cmd,
   input  logic [ADDR_W-1:0]     key,
   input  logic [PAYLOAD_W-1:0]  new_payload,
   output store_status_type      status,
   output logic [ADDR_W-1:0]     rd_key,
   output logic [PAYLOAD_W-1:0]  rd_payload
);

   localparam int ENTRY_W = ADDR_W + PAYLOAD_W;
   localparam int IW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW      = $clog2(DEPTH + 1);
   localparam int SW      = CW + 1;
   localparam logic [CW-1:0] FULL    = CW'(DEPTH);
   localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);
   localparam logic [IW-1:0] LAST_IX = IW'(DEPTH - 1);

   logic [IW-1:0]      head_ff, head_in, head_inc;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      off_ff, off_in, off_next, rd_off;
   logic [SW-1:0]      rd_sum, wr_sum;
   logic [IW-1:0]      rd_addr, wr_addr;
   logic [ENTRY_W-1:0] rd_data, wr_data;
   logic               rd_en, wr_en, full;

   assign full     = (count_ff == FULL);
   assign off_next = off_ff + CW'(1);
   assign head_inc = (head_ff == LAST_IX) ? '0 : head_ff + IW'(1);
   assign rd_off   = cmd.rd_next ? off_next : off_ff;

   // logical offset to physical slot: sum stays below twice the depth
   always_comb begin
      rd_sum  = SW'(head_ff) + SW'(rd_off);
      rd_addr = (rd_sum >= DEPTH_S) ? IW'(rd_sum - DEPTH_S) : IW'(rd_sum);
      wr_sum  = SW'(head_ff) + SW'(cmd.append ? count_ff : off_ff);
      wr_addr = (wr_sum >= DEPTH_S) ? IW'(wr_sum - DEPTH_S) : IW'(wr_sum);
   end

   assign rd_en   = cmd.rd_cur || cmd.rd_next;
   assign wr_en   = cmd.append || cmd.wr_shift;
   assign wr_data = cmd.append ? {key, new_payload} : rd_data;

   drq_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      off_in   = off_ff;
      if (cmd.off_clr) begin
         off_in = '0;
      end else if (cmd.off_inc) begin
         off_in = off_next;
      end
      if (cmd.clear) begin
         count_in = '0;
      end else if (cmd.append) begin
         // full: new entry lands on the oldest slot, drop it by advancing head
         if (full) begin
            head_in = head_inc;
         end else begin
            count_in = count_ff + CW'(1);
         end
      end else if (cmd.pop) begin
         head_in  = head_inc;
         count_in = count_ff - CW'(1);
      end else if (cmd.dec) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
         off_ff   <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
         off_ff   <= off_in;
      end
   end

   assign rd_key     = rd_data[ENTRY_W-1 -: ADDR_W];
   assign rd_payload = rd_data[PAYLOAD_W-1:0];

   always_comb begin
      status.at_end    = (off_ff == count_ff);
      status.shift_end = (off_next >= count_ff);
      status.empty     = (count_ff == '0);
      status.one_left  = (count_ff == CW'(1));
      status.hit       = (rd_key == key);
   end

   `DRQ_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= FULL, "count beyond depth")
   `DRQ_ASSERT_IMP(a_read_in_range, clock, reset, cmd.rd_cur, off_ff < count_ff, "read past tail")
   `DRQ_ASSERT_IMP(a_shift_in_range, clock, reset, cmd.rd_next, off_next < count_ff, "shift past tail")
   `DRQ_ASSERT_IMP(a_pop_nonempty, clock, reset, cmd.pop || cmd.dec, count_ff != '0, "remove from empty")
   `DRQ_ASSERT_NEXT(a_append_grows, clock, reset, cmd.append && !full && !cmd.clear, count_ff == $past(count_ff) + CW'(1), "append lost")

endmodule

// ----- src/drq_datapath.sv -----
// Datapath: request latch, take budget, both stores and the result register.
// Depends on drq_pkg and drq_store.
module drq_datapath import drq_pkg::*; #(
   parameter int QUEUE_DEPTH  = DEF_QUEUE_DEPTH,
   parameter int ANSWER_DEPTH = DEF_ANSWER_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  dp_cmd_type        cmd,
   output dp_status_type     status,
   input  logic [TYPE_W-1:0] req_type,
   input  logic [ADDR_W-1:0] addr,
   input  logic [INFO_W-1:0] ask_info,
   input  logic [MAXC_W-1:0] max_count,
   input  logic              allow_in,
   input  logic              rsp_ready,
   output logic              rsp_valid,
   output logic              item_valid,
   output logic [ADDR_W-1:0] item_addr,
   output logic [INFO_W-1:0] item_info,
   output logic              found,
   output logic              allow_out,
   output logic              last
);

   localparam logic [MAXC_W-1:0] MAX_RES = MAXC_W'(MAX_RESULTS);

   op_type            op_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [INFO_W-1:0] info_ff;
   logic              allow_ff;
   logic [MAXC_W-1:0] rem_ff, rem_in;
   logic              ans_allow_ff;

   logic              rsp_valid_ff;
   logic              out_item_valid_ff, out_found_ff, out_allow_ff, out_last_ff;
   logic [ADDR_W-1:0] out_addr_ff;
   logic [INFO_W-1:0] out_info_ff;

   logic              out_item_valid_in, out_found_in, out_allow_in;
   logic [ADDR_W-1:0] out_addr_in;
   logic [INFO_W-1:0] out_info_in;

   store_status_type  pend_status, ans_status;
   logic [ADDR_W-1:0] pend_rd_key, ans_rd_key;
   logic [INFO_W-1:0] pend_rd_info;
   logic [0:0]        ans_rd_allow;

   drq_store #(
      .DEPTH     (QUEUE_DEPTH),
      .PAYLOAD_W (INFO_W)
   ) u_pend (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd.pend),
      .key         (addr_ff),
      .new_payload (info_ff),
      .status      (pend_status),
      .rd_key      (pend_rd_key),
      .rd_payload  (pend_rd_info)
   );

   drq_store #(
      .DEPTH     (ANSWER_DEPTH),
      .PAYLOAD_W (1)
   ) u_ans (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd.ans),
      .key         (addr_ff),
      .new_payload (allow_ff),
      .status      (ans_status),
      .rd_key      (ans_rd_key),
      .rd_payload  (ans_rd_allow)
   );

   // hold the request fields for the whole operation
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff    <= op_type'(req_type);
         addr_ff  <= addr;
         info_ff  <= ask_info;
         allow_ff <= allow_in;
      end
      if (cmd.latch_allow) begin
         ans_allow_ff <= ans_rd_allow[0];
      end
   end

   always_comb begin
      rem_in = rem_ff;
      if (cmd.load_req) begin
         rem_in = (max_count > MAX_RES) ? MAX_RES : max_count;
      end else if (cmd.rem_dec) begin
         rem_in = rem_ff - MAXC_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= '0;
      end else begin
         rem_ff <= rem_in;
      end
   end

   always_comb begin
      out_item_valid_in = 1'b0;
      out_addr_in       = '0;
      out_info_in       = '0;
      out_found_in      = 1'b0;
      out_allow_in      = 1'b0;
      case (cmd.out_kind)
         OUT_REQ: begin
            out_item_valid_in = 1'b1;
            out_addr_in       = pend_rd_key;
            out_info_in       = pend_rd_info;
         end
         OUT_ANS: begin
            out_item_valid_in = 1'b1;
            out_found_in      = 1'b1;
            out_allow_in      = ans_allow_ff;
         end
         default: begin
            out_item_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_item_valid_ff <= out_item_valid_in;
         out_addr_ff       <= out_addr_in;
         out_info_ff       <= out_info_in;
         out_found_ff      <= out_found_in;
         out_allow_ff      <= out_allow_in;
         out_last_ff       <= cmd.out_last;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign item_valid = out_item_valid_ff;
   assign item_addr  = out_addr_ff;
   assign item_info  = out_info_ff;
   assign found      = out_found_ff;
   assign allow_out  = out_allow_ff;
   assign last       = out_last_ff;

   always_comb begin
      status.op        = op_ff;
      status.addr_zero = (addr_ff == '0);
      status.rem_zero  = (rem_ff == '0);
      status.rem_one   = (rem_ff == MAXC_W'(1));
      status.out_free  = !rsp_valid_ff || rsp_ready;
      status.pend      = pend_status;
      status.ans       = ans_status;
   end

endmodule

// ----- src/drq_ctrl.sv -----
// Controller: sequences scans, shifts, appends and result loads per request.
// Depends on drq_pkg.
module drq_ctrl import drq_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      take_last;

   assign take_last = status.rem_one || status.pend.one_left;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            case (status.op)
               OP_PUSH, OP_ANSWER:
                  state_in = status.addr_zero ? ST_IDLE : ST_P_SCAN_RD;
               OP_TAKE:
                  state_in = (status.rem_zero || status.pend.empty) ? ST_EMIT_NONE
                                                                   : ST_TAKE_RD;
               OP_TAKE_ANS:
                  state_in = ST_A_SCAN_RD;
               default:
                  state_in = ST_IDLE;
            endcase
         end
         ST_P_SCAN_RD: begin
            if (status.pend.at_end) begin
               state_in = (status.op == OP_PUSH) ? ST_P_APPEND : ST_A_SCAN_RD;
            end else begin
               state_in = ST_P_SCAN_CMP;
            end
         end
         ST_P_SCAN_CMP: begin
            if (status.pend.hit) begin
               state_in = (status.op == OP_PUSH) ? ST_IDLE : ST_P_SHIFT_RD;
            end else begin
               state_in = ST_P_SCAN_RD;
            end
         end
         ST_P_SHIFT_RD: begin
            state_in = status.pend.shift_end ? ST_A_SCAN_RD : ST_P_SHIFT_WR;
         end
         ST_P_SHIFT_WR: state_in = ST_P_SHIFT_RD;
         ST_P_APPEND:   state_in = ST_IDLE;
         ST_A_SCAN_RD: begin
            if (status.ans.at_end) begin
               state_in = (status.op == OP_ANSWER) ? ST_A_APPEND : ST_EMIT_NONE;
            end else begin
               state_in = ST_A_SCAN_CMP;
            end
         end
         ST_A_SCAN_CMP: begin
            state_in = status.ans.hit ? ST_A_SHIFT_RD : ST_A_SCAN_RD;
         end
         ST_A_SHIFT_RD: begin
            if (status.ans.shift_end) begin
               state_in = (status.op == OP_ANSWER) ? ST_A_APPEND : ST_EMIT_ANS;
            end else begin
               state_in = ST_A_SHIFT_WR;
            end
         end
         ST_A_SHIFT_WR: state_in = ST_A_SHIFT_RD;
         ST_A_APPEND:   state_in = ST_IDLE;
         ST_TAKE_RD:    state_in = ST_TAKE_EMIT;
         ST_TAKE_EMIT: begin
            if (status.out_free) state_in = take_last ? ST_IDLE : ST_TAKE_RD;
         end
         ST_EMIT_NONE, ST_EMIT_ANS: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready        = 1'b1;
            cmd.load_req     = req_valid;
            cmd.pend.off_clr = 1'b1;
            cmd.ans.off_clr  = 1'b1;
         end
         ST_DECODE: begin
            if (status.op == OP_CLEAR) begin
               cmd.pend.clear = 1'b1;
               cmd.ans.clear  = 1'b1;
            end
         end
         ST_P_SCAN_RD:  cmd.pend.rd_cur  = !status.pend.at_end;
         ST_P_SCAN_CMP: cmd.pend.off_inc = !status.pend.hit;
         ST_P_SHIFT_RD: begin
            cmd.pend.dec     = status.pend.shift_end;
            cmd.pend.rd_next = !status.pend.shift_end;
         end
         ST_P_SHIFT_WR: begin
            cmd.pend.wr_shift = 1'b1;
            cmd.pend.off_inc  = 1'b1;
         end
         ST_P_APPEND:   cmd.pend.append = 1'b1;
         ST_A_SCAN_RD:  cmd.ans.rd_cur  = !status.ans.at_end;
         ST_A_SCAN_CMP: begin
            cmd.latch_allow = status.ans.hit;
            cmd.ans.off_inc = !status.ans.hit;
         end
         ST_A_SHIFT_RD: begin
            cmd.ans.dec     = status.ans.shift_end;
            cmd.ans.rd_next = !status.ans.shift_end;
         end
         ST_A_SHIFT_WR: begin
            cmd.ans.wr_shift = 1'b1;
            cmd.ans.off_inc  = 1'b1;
         end
         ST_A_APPEND:   cmd.ans.append = 1'b1;
         ST_TAKE_RD:    cmd.pend.rd_cur = 1'b1;
         ST_TAKE_EMIT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_kind = OUT_REQ;
               cmd.out_last = take_last;
               cmd.pend.pop = 1'b1;
               cmd.rem_dec  = 1'b1;
            end
         end
         ST_EMIT_NONE: begin
            cmd.out_load = status.out_free;
            cmd.out_kind = OUT_NONE;
            cmd.out_last = 1'b1;
         end
         ST_EMIT_ANS: begin
            cmd.out_load = status.out_free;
            cmd.out_kind = OUT_ANS;
            cmd.out_last = 1'b1;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- src/dedup_request_queue_with_answers.sv -----
// Pairing request queue with answer table. One request is handled at a time;
// req_chan takes a new transfer only when the previous request has finished its
// store work (its last result may still sit in the result register). Both
// stores are circular RAMs with a single registered read port, and that port
// sets the cost: a scan or a removal shift reads each entry it visits before
// comparing or moving it. Push scans the pending entries (a duplicate ends the
// scan early; a zero address skips it). Answer runs the pending and answer
// scans plus the shift that closes each removed slot (none for a zero address).
// Take-answer scans the answers. Take loads one result per emitted entry, or
// one empty result when nothing is emitted. Clear empties both stores. Each
// result load also waits while the result register still holds an unaccepted
// transfer. No clearing pass after reset; counts start at zero. Full stores
// drop their oldest entry by advancing the head pointer.
// Depends on drq_pkg, drq_req_if, drq_rsp_if, drq_datapath and drq_ctrl.
module dedup_request_queue_with_answers import drq_pkg::*; #(
   parameter int QUEUE_DEPTH  = DEF_QUEUE_DEPTH,
   parameter int ANSWER_DEPTH = DEF_ANSWER_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   drq_req_if.sink     req_chan,
   drq_rsp_if.source   rsp_chan
);

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   // sequence each request: scan, shift out matches, append, load results
   drq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (dp_status),
      .cmd       (dp_cmd)
   );

   // stores, request latch and the result register that decouples rsp_chan
   drq_datapath #(
      .QUEUE_DEPTH  (QUEUE_DEPTH),
      .ANSWER_DEPTH (ANSWER_DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (dp_cmd),
      .status     (dp_status),
      .req_type   (req_chan.req_type),
      .addr       (req_chan.addr),
      .ask_info   (req_chan.ask_info),
      .max_count  (req_chan.max_count),
      .allow_in   (req_chan.allow_in),
      .rsp_ready  (rsp_chan.ready),
      .rsp_valid  (rsp_chan.valid),
      .item_valid (rsp_chan.item_valid),
      .item_addr  (rsp_chan.item_addr),
      .item_info  (rsp_chan.item_info),
      .found      (rsp_chan.found),
      .allow_out  (rsp_chan.allow_out),
      .last       (rsp_chan.last)
   );

endmodule

// ----- sim/tb_dedup_request_queue_with_answers.sv -----
// Self-checking bench for the pairing request queue with answer table.
// Needs drq_pkg, drq_req_if, drq_rsp_if and dedup_request_queue_with_answers.
`timescale 1ns / 100ps

module tb_dedup_request_queue_with_answers;
   import drq_pkg::*;

   localparam int QUEUE_DEPTH   = DEF_QUEUE_DEPTH;
   localparam int ANSWER_DEPTH  = DEF_ANSWER_DEPTH;
   localparam int RANDOM_OPS    = 400;
   localparam int DRAIN_EVERY   = 60;
   localparam int POOL_SIZE     = 24;
   localparam int TAIL_OPS      = 60;
   localparam int LONG_HOLD     = 400;
   localparam int HOLD_AFTER    = 150;
   localparam int SETTLE_CYCLES = 100;
   localparam int CYCLE_LIMIT   = 300000;
   localparam int TYPE_CODES    = 1 << TYPE_W;
   localparam int MAXC_TOP      = (1 << MAXC_W) - 1;

   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic [INFO_W-1:0] info;
   } pend_entry_type;

   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic              allow;
   } ans_entry_type;

   typedef struct packed {
      logic              item_valid;
      logic [ADDR_W-1:0] item_addr;
      logic [INFO_W-1:0] item_info;
      logic              found;
      logic              allow_out;
      logic              last;
   } pair_result_type;

   typedef struct {
      logic [TYPE_W-1:0] kind;
      logic [ADDR_W-1:0] addr;
      logic [INFO_W-1:0] info;
      logic [MAXC_W-1:0] max_count;
      logic              allow;
      bit                drain_first;
   } pair_op_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   drq_req_if req_if ();
   drq_rsp_if rsp_if ();

   dedup_request_queue_with_answers #(
      .QUEUE_DEPTH  (QUEUE_DEPTH),
      .ANSWER_DEPTH (ANSWER_DEPTH)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   // Shadow copies of both stores; index 0 is the oldest entry.
   pend_entry_type  pend_shadow[$];
   ans_entry_type   ans_shadow[$];
   pair_result_type outputs_due[$];
   pair_op_type     op_stream[$];

   logic [ADDR_W-1:0] addr_pool[POOL_SIZE];

   int  op_hits[TYPE_CODES];
   int  ops_accepted    = 0;
   int  results_checked = 0;
   int  mismatches      = 0;
   int  deepest_pend    = 0;
   int  deepest_ans     = 0;
   int  cycle_count     = 0;
   int  gap_left        = 0;
   int  idle_left       = 0;
   int  long_left       = 0;
   bit  long_done       = 1'b0;
   bit  tail_phase      = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Append one prediction at the back of the expected-result queue.
   task automatic expect_result(input pair_result_type res);
      outputs_due.insert(outputs_due.size(), res);
   endtask

   // Predict the results of one accepted transfer and advance the shadow stores.
   task automatic run_pairing_op(input logic [TYPE_W-1:0] kind,
                                 input logic [ADDR_W-1:0] addr,
                                 input logic [INFO_W-1:0] info,
                                 input logic [MAXC_W-1:0] maxc,
                                 input logic              allow);
      int             n;
      bit             hit;
      pend_entry_type kept[$];
      op_hits[kind]++;
      case (kind)
         OP_PUSH: begin
            hit = 1'b0;
            foreach (pend_shadow[i])
               if (pend_shadow[i].addr == addr) hit = 1'b1;
            // Zero address and duplicates leave the queue untouched.
            if (addr != '0 && !hit) begin
               if (pend_shadow.size() >= QUEUE_DEPTH) void'(pend_shadow.pop_front());
               pend_shadow.insert(pend_shadow.size(), '{addr: addr, info: info});
            end
         end
         OP_TAKE: begin
            n = maxc;
            if (n > pend_shadow.size()) n = pend_shadow.size();
            if (n > MAX_RESULTS) n = MAX_RESULTS;
            if (n == 0) begin
               expect_result('{1'b0, '0, '0, 1'b0, 1'b0, 1'b1});
            end else begin
               for (int k = 0; k < n; k++) begin
                  expect_result('{1'b1, pend_shadow[0].addr, pend_shadow[0].info,
                                  1'b0, 1'b0, logic'(k == n - 1)});
                  void'(pend_shadow.pop_front());
               end
            end
         end
         OP_ANSWER: begin
            if (addr != '0) begin
               // Withdraw every pending request for this address.
               foreach (pend_shadow[i])
                  if (pend_shadow[i].addr != addr) kept.insert(kept.size(), pend_shadow[i]);
               pend_shadow = kept;
               // A new decision replaces the old one; a full table drops its oldest.
               for (int k = 0; k < ans_shadow.size(); k++) begin
                  if (ans_shadow[k].addr == addr) begin
                     ans_shadow.delete(k);
                     break;
                  end
               end
               if (ans_shadow.size() >= ANSWER_DEPTH) void'(ans_shadow.pop_front());
               ans_shadow.insert(ans_shadow.size(), '{addr: addr, allow: allow});
            end
         end
         OP_TAKE_ANS: begin
            hit = 1'b0;
            for (int k = 0; k < ans_shadow.size(); k++) begin
               if (ans_shadow[k].addr == addr) begin
                  expect_result('{1'b1, '0, '0, 1'b1, ans_shadow[k].allow, 1'b1});
                  ans_shadow.delete(k);
                  hit = 1'b1;
                  break;
               end
            end
            if (!hit) expect_result('{1'b0, '0, '0, 1'b0, 1'b0, 1'b1});
         end
         OP_CLEAR: begin
            pend_shadow.delete();
            ans_shadow.delete();
         end
         default: ;  // spare codes are ignored
      endcase
      if (pend_shadow.size() > deepest_pend) deepest_pend = pend_shadow.size();
      if (ans_shadow.size() > deepest_ans) deepest_ans = ans_shadow.size();
   endtask

   task automatic add_op(input logic [TYPE_W-1:0] kind, input logic [ADDR_W-1:0] addr,
                         input logic [INFO_W-1:0] info, input logic [MAXC_W-1:0] maxc,
                         input logic allow, input bit drain_first);
      pair_op_type op;
      op = '{kind, addr, info, maxc, allow, drain_first};
      op_stream.insert(op_stream.size(), op);
   endtask

   // Mostly pool addresses so duplicates, withdrawals and hits happen often.
   function automatic logic [ADDR_W-1:0] pick_addr();
      int roll;
      roll = $urandom_range(0, 19);
      if (roll == 0) return '0;
      if (roll < 3) return ADDR_W'({$urandom, $urandom});
      return addr_pool[$urandom_range(0, POOL_SIZE - 1)];
   endfunction

   // Driver: present one queued transfer at a time, with random gaps.
   always @(posedge clock) begin
      pair_op_type nxt;
      if (reset) begin
         req_if.valid     <= 1'b0;
         req_if.req_type  <= OP_PUSH;
         req_if.addr      <= '0;
         req_if.ask_info  <= '0;
         req_if.max_count <= '0;
         req_if.allow_in  <= 1'b0;
         gap_left         <= 0;
      end else begin
         tail_phase <= (op_stream.size() < TAIL_OPS);
         if (req_if.valid && req_if.ready) begin
            run_pairing_op(req_if.req_type, req_if.addr, req_if.ask_info,
                           req_if.max_count, req_if.allow_in);
            ops_accepted <= ops_accepted + 1;
         end
         if (!req_if.valid || req_if.ready) begin
            if (gap_left != 0) begin
               gap_left     <= gap_left - 1;
               req_if.valid <= 1'b0;
            end else if (!tail_phase && $urandom_range(0, 5) == 0) begin
               gap_left     <= $urandom_range(0, 3);
               req_if.valid <= 1'b0;
            end else if (op_stream.size() != 0 &&
                         !(op_stream[0].drain_first && outputs_due.size() != 0)) begin
               // Hold a drain-marked transfer back until every result is in.
               nxt = op_stream.pop_front();
               req_if.valid     <= 1'b1;
               req_if.req_type  <= nxt.kind;
               req_if.addr      <= nxt.addr;
               req_if.ask_info  <= nxt.info;
               req_if.max_count <= nxt.max_count;
               req_if.allow_in  <= nxt.allow;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // Result side readiness: short random bursts, plus one long hold-off so that
   // the result register backs up and the block stops taking requests.
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (long_left != 0) begin
         long_left    <= long_left - 1;
         rsp_if.ready <= 1'b0;
      end else if (!long_done && ops_accepted >= HOLD_AFTER) begin
         long_done    <= 1'b1;
         long_left    <= LONG_HOLD - 1;
         rsp_if.ready <= 1'b0;
      end else if (idle_left != 0) begin
         idle_left    <= idle_left - 1;
         rsp_if.ready <= 1'b0;
      end else if (!tail_phase && $urandom_range(0, 5) == 0) begin
         idle_left    <= $urandom_range(0, 3);
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   // Monitor: compare each result transfer against the oldest prediction.
   always @(posedge clock) begin
      pair_result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (outputs_due.size() == 0) begin
            $error("result transfer with nothing outstanding");
            mismatches++;
         end else begin
            want = outputs_due.pop_front();
            results_checked++;
            if (rsp_if.item_valid !== want.item_valid) begin
               $error("item_valid: expected %0b, got %0b", want.item_valid, rsp_if.item_valid);
               mismatches++;
            end
            if (rsp_if.item_addr !== want.item_addr) begin
               $error("item_addr: expected %h, got %h", want.item_addr, rsp_if.item_addr);
               mismatches++;
            end
            if (rsp_if.item_info !== want.item_info) begin
               $error("item_info: expected %h, got %h", want.item_info, rsp_if.item_info);
               mismatches++;
            end
            if (rsp_if.found !== want.found) begin
               $error("found: expected %0b, got %0b", want.found, rsp_if.found);
               mismatches++;
            end
            if (rsp_if.allow_out !== want.allow_out) begin
               $error("allow_out: expected %0b, got %0b", want.allow_out, rsp_if.allow_out);
               mismatches++;
            end
            if (rsp_if.last !== want.last) begin
               $error("last: expected %0b, got %0b", want.last, rsp_if.last);
               mismatches++;
            end
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      logic [ADDR_W-1:0] all_ones;
      logic [ADDR_W-1:0] top_bit;
      logic [TYPE_W-1:0] kind;
      logic [ADDR_W-1:0] addr;
      logic [MAXC_W-1:0] maxc;
      int                roll;
      int                real_ops;
      int                spare_hits;

      all_ones = '1;
      top_bit  = '0;
      top_bit[ADDR_W-1] = 1'b1;
      addr_pool[0] = all_ones;
      addr_pool[1] = ADDR_W'(1);
      addr_pool[2] = top_bit;
      addr_pool[3] = {(ADDR_W / 2){2'b01}};
      addr_pool[4] = {(ADDR_W / 2){2'b10}};
      for (int k = 5; k < POOL_SIZE; k++) addr_pool[k] = ADDR_W'({$urandom, $urandom});

      // Directed: empty takes, zero addresses, duplicates, replaced decisions,
      // spare codes and a clear.
      add_op(OP_TAKE,     '0,        '0,    MAXC_W'(MAX_RESULTS), 1'b0, 1'b0);
      add_op(OP_TAKE_ANS, '0,        '0,    '0,  1'b1, 1'b0);
      add_op(OP_PUSH,     '0,        '1,    '0,  1'b0, 1'b0);
      add_op(OP_PUSH,     all_ones,  '1,    '0,  1'b0, 1'b0);
      add_op(OP_PUSH,     addr_pool[1], '0, '1,  1'b1, 1'b0);
      add_op(OP_PUSH,     all_ones,  32'h0000_1234, '0, 1'b0, 1'b0);
      add_op(OP_TAKE,     '0,        '0,    '0,  1'b0, 1'b0);
      add_op(OP_TAKE,     '0,        '0,    MAXC_W'(MAXC_TOP), 1'b0, 1'b0);
      add_op(OP_ANSWER,   '0,        '0,    '0,  1'b1, 1'b0);
      add_op(OP_PUSH,     top_bit,   32'hA5A5_A5A5, '0, 1'b0, 1'b0);
      add_op(OP_ANSWER,   top_bit,   '0,    '0,  1'b1, 1'b0);
      add_op(OP_ANSWER,   top_bit,   '0,    '0,  1'b0, 1'b0);
      add_op(OP_TAKE_ANS, top_bit,   '0,    '0,  1'b0, 1'b0);
      add_op(OP_TAKE_ANS, top_bit,   '0,    '0,  1'b0, 1'b0);
      add_op(OP_ANSWER,   all_ones,  '0,    '0,  1'b1, 1'b0);
      add_op(OP_TAKE_ANS, all_ones,  '0,    '0,  1'b0, 1'b0);
      for (int k = OP_CLEAR + 1; k < TYPE_CODES; k++)
         add_op(TYPE_W'(k), all_ones, '1, '1, 1'b1, 1'b0);
      add_op(OP_PUSH,     all_ones,  32'h8000_0001, '0, 1'b0, 1'b0);
      add_op(OP_ANSWER,   addr_pool[1], '0, '0,  1'b1, 1'b0);
      add_op(OP_CLEAR,    '0,        '0,    '0,  1'b0, 1'b0);
      add_op(OP_TAKE,     '0,        '0,    MAXC_W'(MAX_RESULTS), 1'b0, 1'b0);
      add_op(OP_TAKE_ANS, addr_pool[1], '0, '0,  1'b0, 1'b0);

      // Random: mostly pushes and answers over a small address pool, with
      // occasional noise, clears and spare codes.
      real_ops = 0;
      while (real_ops < RANDOM_OPS) begin
         roll = $urandom_range(0, 99);
         addr = pick_addr();
         if (roll < 40)      kind = OP_PUSH;
         else if (roll < 55) kind = OP_TAKE;
         else if (roll < 72) kind = OP_ANSWER;
         else if (roll < 90) kind = OP_TAKE_ANS;
         else if (roll < 93) kind = OP_CLEAR;
         else if (roll < 96) kind = TYPE_W'($urandom_range(OP_CLEAR + 1, TYPE_CODES - 1));
         else                kind = OP_PUSH;
         maxc = ($urandom_range(0, 3) == 0) ? MAXC_W'($urandom_range(0, MAXC_TOP))
                                            : MAXC_W'($urandom_range(1, 4));
         add_op(kind, addr, $urandom, maxc, 1'($urandom_range(0, 1)),
                (real_ops % DRAIN_EVERY) == 0);
         if (kind <= OP_CLEAR && !(addr == '0 && (kind == OP_PUSH || kind == OP_ANSWER)))
            real_ops++;
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (op_stream.size() != 0 || req_if.valid || outputs_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      spare_hits = 0;
      for (int k = OP_CLEAR + 1; k < TYPE_CODES; k++) spare_hits += op_hits[k];
      $display("Ran %0d requests: %0d push, %0d take, %0d answer, %0d take-answer, %0d clear,",
               ops_accepted, op_hits[OP_PUSH], op_hits[OP_TAKE], op_hits[OP_ANSWER],
               op_hits[OP_TAKE_ANS], op_hits[OP_CLEAR]);
      $display("%0d spare; %0d results checked; queue peaked at %0d/%0d, answers at %0d/%0d.",
               spare_hits, results_checked, deepest_pend, QUEUE_DEPTH,
               deepest_ans, ANSWER_DEPTH);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ----- dedup_request_queue_with_answers.f -----
+incdir+src
src/drq_pkg.sv
src/drq_req_if.sv
src/drq_rsp_if.sv
src/drq_ram.sv
src/drq_store.sv
src/drq_datapath.sv
src/drq_ctrl.sv
src/dedup_request_queue_with_answers.sv
sim/tb_dedup_request_queue_with_answers.sv
